[hw/rtl/m3ca_pkg.sv]
package m3ca_pkg;

   localparam int ROW_STRIDE  = 4;
   localparam int RES_W       = 2;
   localparam int ROW_W       = ROW_STRIDE * RES_W;
   localparam int ENTRY_W     = 16;
   localparam int ACTION_W    = 2;
   localparam int SLOT_W      = 8;
   localparam int ROWIDX_W    = 2;
   localparam int LABEL_W     = 6;
   localparam int REP_J_W     = 6;
   localparam int WIT_OUT_W   = 8;
   localparam int TOTAL_W     = 9;
   localparam int REP_COUNT_W = 7;
   localparam int WIT_COUNT_W = 9;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [ACTION_W-1:0] ACT_LOAD_REP = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD_WIT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_REP_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIT_COUNT = 8'd1;

   typedef logic [RES_W-1:0] res_type;
   typedef res_type [ROW_STRIDE-1:0] row_type;
   typedef row_type [ROW_STRIDE-1:0] mat_type;

   typedef struct packed {
      logic                                rep_we;
      logic                                wit_we;
      logic [ROWIDX_W-1:0]                 row;
      logic [SLOT_W-1:0]                   slot;
      logic [LABEL_W-1:0]                  label;
      logic [ROW_STRIDE-1:0][ENTRY_W-1:0]  entries;
   } load_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } match_type;

   // true residue mod 3 of a signed 16-bit value, base-4 digit sum
   function automatic res_type residue3(input logic [ENTRY_W-1:0] v);
      logic [5:0] s;
      s = 6'd0;
      for (int d = 0; d < ENTRY_W / 2; d++) begin
         s = s + 6'(v[2*d +: 2]);
      end
      if (v[ENTRY_W-1]) begin
         s = s + 6'd2;
      end
      if (s >= 6'd24) s = s - 6'd24;
      if (s >= 6'd12) s = s - 6'd12;
      if (s >= 6'd6)  s = s - 6'd6;
      if (s >= 6'd3)  s = s - 6'd3;
      return res_type'(s);
   endfunction

   // mod 3 of a dot product sum, at most 16
   function automatic res_type mod3_small(input logic [4:0] v);
      logic [4:0] s;
      s = v;
      if (s >= 5'd12) s = s - 5'd12;
      if (s >= 5'd6)  s = s - 5'd6;
      if (s >= 5'd3)  s = s - 5'd3;
      return res_type'(s);
   endfunction

endpackage

[hw/rtl/m3ca_if.sv]
interface m3ca_req_if;
   logic                               valid;
   logic                               ready;
   logic [m3ca_pkg::ACTION_W-1:0]      action;
   logic [m3ca_pkg::SLOT_W-1:0]        slot;
   logic [m3ca_pkg::ROWIDX_W-1:0]      row_index;
   logic [m3ca_pkg::LABEL_W-1:0]       edge_label;
   logic signed [m3ca_pkg::ENTRY_W-1:0] entry0;
   logic signed [m3ca_pkg::ENTRY_W-1:0] entry1;
   logic signed [m3ca_pkg::ENTRY_W-1:0] entry2;
   logic signed [m3ca_pkg::ENTRY_W-1:0] entry3;

   modport source (output valid, action, slot, row_index, edge_label,
                   entry0, entry1, entry2, entry3, input ready);
   modport sink   (input valid, action, slot, row_index, edge_label,
                   entry0, entry1, entry2, entry3, output ready);
endinterface

interface m3ca_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [m3ca_pkg::REP_J_W-1:0]    rep_j;
   logic                            is_edge;
   logic [m3ca_pkg::WIT_OUT_W-1:0]  first_witness;
   logic [m3ca_pkg::TOTAL_W-1:0]    match_total;
   logic                            last;

   modport source (output valid, rep_j, is_edge, first_witness, match_total, last,
                   input ready);
   modport sink   (input valid, rep_j, is_edge, first_witness, match_total, last,
                   output ready);
endinterface

interface m3ca_csr_if;
   logic                             valid;
   logic                             ready;
   logic [m3ca_pkg::CSR_IDX_W-1:0]   index;
   logic [m3ca_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/m3ca_ram.sv]
module m3ca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/m3ca_tables.sv]
module m3ca_tables #(
   parameter int MAX_REPS      = 64,
   parameter int MAX_WITNESSES = 256,
   parameter int MAX_LABELS    = 64,
   parameter int MATRIX_DIM    = 4,
   localparam int RAW = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1,
   localparam int WAW = (MAX_WITNESSES > 1) ? $clog2(MAX_WITNESSES) : 1
) (
   input  logic                        clock,
   input  m3ca_pkg::load_type          load,
   input  logic [RAW-1:0]              rep_raddr,
   output m3ca_pkg::mat_type           rep_rdata,
   input  logic [WAW-1:0]              wit_raddr,
   output m3ca_pkg::mat_type           wit_rdata,
   output logic [m3ca_pkg::LABEL_W-1:0] wit_label
);

   import m3ca_pkg::*;

   row_type        row_res;
   logic           rep_ok;
   logic           wit_ok;
   logic [RAW-1:0] rep_waddr;
   logic [WAW-1:0] wit_waddr;

   always_comb begin
      for (int c = 0; c < ROW_STRIDE; c++) begin
         row_res[c] = (c < MATRIX_DIM) ? residue3(load.entries[c]) : '0;
      end
   end

   assign rep_ok    = load.rep_we && (32'(load.slot) < MAX_REPS);
   assign wit_ok    = load.wit_we && (32'(load.slot) < MAX_WITNESSES)
                      && (32'(load.label) < MAX_LABELS)
                      && (32'(load.row) < MATRIX_DIM);
   assign rep_waddr = RAW'(load.slot);
   assign wit_waddr = WAW'(load.slot);

   for (genvar r = 0; r < ROW_STRIDE; r++) begin : g_row
      if (r < MATRIX_DIM) begin : g_used
         m3ca_ram #(.WIDTH(ROW_W), .DEPTH(MAX_REPS)) u_rep_row (
            .clock   (clock),
            .wr_en   (rep_ok && (load.row == ROWIDX_W'(r))),
            .wr_addr (rep_waddr),
            .wr_data (row_res),
            .rd_addr (rep_raddr),
            .rd_data (rep_rdata[r])
         );
         m3ca_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WITNESSES)) u_wit_row (
            .clock   (clock),
            .wr_en   (wit_ok && (load.row == ROWIDX_W'(r))),
            .wr_addr (wit_waddr),
            .wr_data (row_res),
            .rd_addr (wit_raddr),
            .rd_data (wit_rdata[r])
         );
      end else begin : g_unused
         assign rep_rdata[r] = '0;
         assign wit_rdata[r] = '0;
      end
   end

   m3ca_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_WITNESSES)) u_wit_label (
      .clock   (clock),
      .wr_en   (wit_ok),
      .wr_addr (wit_waddr),
      .wr_data (load.label),
      .rd_addr (wit_raddr),
      .rd_data (wit_label)
   );

endmodule

[hw/rtl/m3ca_match.sv]
module m3ca_match #(
   parameter int MATRIX_DIM = 4,
   parameter int KW         = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [KW-1:0]                in_k,
   input  m3ca_pkg::mat_type            ri,
   input  m3ca_pkg::mat_type            rj,
   input  m3ca_pkg::mat_type            wit,
   input  logic [m3ca_pkg::LABEL_W-1:0] wit_label,
   input  logic [m3ca_pkg::LABEL_W-1:0] query_label,
   output m3ca_pkg::match_type          result,
   output logic [KW-1:0]                result_k
);

   import m3ca_pkg::*;

   logic          prod_ok;
   logic          valid_ff;
   logic          hit_ff;
   logic [KW-1:0] k_ff;

   // rj * wit == ri over the active dimension, mod 3
   always_comb begin
      logic [4:0] s;
      prod_ok = 1'b1;
      s = 5'd0;
      for (int r = 0; r < ROW_STRIDE; r++) begin
         for (int c = 0; c < ROW_STRIDE; c++) begin
            if (r < MATRIX_DIM && c < MATRIX_DIM) begin
               s = 5'd0;
               for (int k = 0; k < ROW_STRIDE; k++) begin
                  if (k < MATRIX_DIM) begin
                     s = s + 5'(rj[r][k]) * 5'(wit[k][c]);
                  end
               end
               if (mod3_small(s) != ri[r][c]) begin
                  prod_ok = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= prod_ok && (wit_label == query_label);
      k_ff   <= in_k;
   end

   assign result.valid = valid_ff;
   assign result.hit   = hit_ff;
   assign result_k     = k_ff;

endmodule

[hw/rtl/mod3_matrix_coset_adjacency_top.sv]
// channel   | dir | beat
// ----------+-----+------------------------------------------------------------
// req_chan  | in  | load rep row, load witness row, or query (label, rep i)
// rsp_chan  | out | one per j in i..count-1: j, edge flag, first witness, total
// csr_chan  | in  | register write: index 0 rep_count, index 1 witness_count
//
// a load completes on its beat; a query holds off the next req beat until every j is done:
// per j, rep j is read, then the witness table is scanned, one matrix per cycle through its
// single port, and the match pipeline drains; with the label out of range or no witnesses
// the scan is skipped; results wait in an output register while the next j is scanned; a stalled rsp_chan
// holds the sequencer at the result step
// reset is synchronous; the tables need no clearing and are usable at once
module mod3_matrix_coset_adjacency_top #(
   parameter int MAX_REPS      = 64,
   parameter int MAX_WITNESSES = 256,
   parameter int MAX_LABELS    = 64,
   parameter int MATRIX_DIM    = 4
) (
   input  logic       clock,
   input  logic       reset,
   m3ca_req_if.sink   req_chan,
   m3ca_rsp_if.source rsp_chan,
   m3ca_csr_if.sink   csr_chan
);

   import m3ca_pkg::*;

   localparam int RAW = (MAX_REPS > 1) ? $clog2(MAX_REPS) : 1;
   localparam int WAW = (MAX_WITNESSES > 1) ? $clog2(MAX_WITNESSES) : 1;
   localparam int NRW = $clog2(MAX_REPS + 1);
   localparam int NWW = $clog2(MAX_WITNESSES + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RD_I  = 3'd1;
   localparam logic [2:0] ST_LD_I  = 3'd2;
   localparam logic [2:0] ST_RD_J  = 3'd3;
   localparam logic [2:0] ST_LD_J  = 3'd4;
   localparam logic [2:0] ST_SCAN  = 3'd5;
   localparam logic [2:0] ST_DRAIN = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0]             state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   p1_valid_ff;
   logic [REP_COUNT_W-1:0] rep_count_ff;
   logic [WIT_COUNT_W-1:0] wit_count_ff;

   logic [RAW-1:0]         i_ff, j_ff;
   logic [NRW-1:0]         nreps_ff;
   logic [NWW-1:0]         nwit_ff;
   logic [LABEL_W-1:0]     qlabel_ff;
   logic                   scan_ok_ff;
   mat_type                ri_ff, rj_ff;
   logic [WAW-1:0]         k_ff, p1_k_ff, first_ff;
   logic [TOTAL_W-1:0]     total_ff;
   logic                   found_ff;

   logic [REP_J_W-1:0]     rsp_rep_j_ff;
   logic                   rsp_is_edge_ff;
   logic [WIT_OUT_W-1:0]   rsp_first_ff;
   logic [TOTAL_W-1:0]     rsp_total_ff;
   logic                   rsp_last_ff;

   logic                   req_fire, csr_fire, rsp_free, is_query;
   logic                   q_ok, label_ok, k_last, j_last;
   logic [REP_COUNT_W-1:0] nreps_clamp;
   logic [NWW-1:0]         nwit_clamp;
   load_type               load;
   mat_type                rep_rdata, wit_rdata;
   logic [LABEL_W-1:0]     wit_label;
   match_type              match;
   logic [WAW-1:0]         match_k;
   logic [RAW-1:0]         rep_raddr;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign is_query       = (req_chan.action == ACT_QUERY);
   assign csr_chan.ready = 1'b1;
   assign csr_fire       = csr_chan.valid && csr_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign nreps_clamp = (32'(rep_count_ff) > MAX_REPS) ? REP_COUNT_W'(MAX_REPS)
                                                        : rep_count_ff;
   assign nwit_clamp  = (32'(wit_count_ff) > MAX_WITNESSES) ? NWW'(MAX_WITNESSES)
                                                             : NWW'(wit_count_ff);
   assign q_ok        = 32'(req_chan.slot) < 32'(nreps_clamp);
   assign label_ok    = 32'(req_chan.edge_label) < MAX_LABELS;
   assign k_last      = (NWW'(k_ff) + NWW'(1)) == nwit_ff;
   assign j_last      = (NRW'(j_ff) + NRW'(1)) == nreps_ff;
   assign rep_raddr   = (state_ff == ST_RD_I) ? i_ff : j_ff;

   always_comb begin
      load.rep_we     = req_fire && (req_chan.action == ACT_LOAD_REP);
      load.wit_we     = req_fire && (req_chan.action == ACT_LOAD_WIT);
      load.row        = req_chan.row_index;
      load.slot       = req_chan.slot;
      load.label      = req_chan.edge_label;
      load.entries[0] = req_chan.entry0;
      load.entries[1] = req_chan.entry1;
      load.entries[2] = req_chan.entry2;
      load.entries[3] = req_chan.entry3;
   end

   m3ca_tables #(
      .MAX_REPS      (MAX_REPS),
      .MAX_WITNESSES (MAX_WITNESSES),
      .MAX_LABELS    (MAX_LABELS),
      .MATRIX_DIM    (MATRIX_DIM)
   ) u_tables (
      .clock     (clock),
      .load      (load),
      .rep_raddr (rep_raddr),
      .rep_rdata (rep_rdata),
      .wit_raddr (k_ff),
      .wit_rdata (wit_rdata),
      .wit_label (wit_label)
   );

   m3ca_match #(
      .MATRIX_DIM (MATRIX_DIM),
      .KW         (WAW)
   ) u_match (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (p1_valid_ff),
      .in_k        (p1_k_ff),
      .ri          (ri_ff),
      .rj          (rj_ff),
      .wit         (wit_rdata),
      .wit_label   (wit_label),
      .query_label (qlabel_ff),
      .result      (match),
      .result_k    (match_k)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_query && q_ok) state_in = ST_RD_I;
         end
         ST_RD_I:  state_in = ST_LD_I;
         ST_LD_I:  state_in = ST_RD_J;
         ST_RD_J:  state_in = ST_LD_J;
         ST_LD_J:  state_in = scan_ok_ff ? ST_SCAN : ST_EMIT;
         ST_SCAN: begin
            if (k_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !match.valid) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) state_in = j_last ? ST_IDLE : ST_RD_J;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rep_count_ff <= REP_COUNT_W'(1);
         wit_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         p1_valid_ff  <= (state_ff == ST_SCAN);
         if (csr_fire) begin
            case (csr_chan.index)
               CSR_REP_COUNT: rep_count_ff <= csr_chan.data[REP_COUNT_W-1:0];
               CSR_WIT_COUNT: wit_count_ff <= csr_chan.data[WIT_COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && is_query) begin
         i_ff       <= RAW'(req_chan.slot);
         j_ff       <= RAW'(req_chan.slot);
         nreps_ff   <= NRW'(nreps_clamp);
         nwit_ff    <= nwit_clamp;
         qlabel_ff  <= req_chan.edge_label;
         scan_ok_ff <= label_ok && (nwit_clamp != '0);
      end
      if (state_ff == ST_LD_I) begin
         ri_ff <= rep_rdata;
      end
      if (state_ff == ST_LD_J) begin
         rj_ff    <= rep_rdata;
         k_ff     <= '0;
         total_ff <= '0;
         found_ff <= 1'b0;
         first_ff <= '0;
      end
      if (state_ff == ST_SCAN) begin
         k_ff <= k_ff + WAW'(1);
      end
      p1_k_ff <= k_ff;
      if (match.valid && match.hit) begin
         found_ff <= 1'b1;
         if (!found_ff) first_ff <= match_k;
         if (total_ff != '1) total_ff <= total_ff + TOTAL_W'(1);
      end
      if (state_ff == ST_EMIT && rsp_free) begin
         rsp_rep_j_ff   <= REP_J_W'(j_ff);
         rsp_is_edge_ff <= found_ff;
         rsp_first_ff   <= WIT_OUT_W'(first_ff);
         rsp_total_ff   <= total_ff;
         rsp_last_ff    <= j_last;
         if (!j_last) j_ff <= j_ff + RAW'(1);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.rep_j         = rsp_rep_j_ff;
   assign rsp_chan.is_edge       = rsp_is_edge_ff;
   assign rsp_chan.first_witness = rsp_first_ff;
   assign rsp_chan.match_total   = rsp_total_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

[hw/rtl/m3ca_checker.sv]
module m3ca_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [m3ca_pkg::REP_J_W-1:0]    rsp_rep_j,
   input logic                            rsp_is_edge,
   input logic [m3ca_pkg::WIT_OUT_W-1:0]  rsp_first_witness,
   input logic [m3ca_pkg::TOTAL_W-1:0]    rsp_match_total,
   input logic                            rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_rep_j) && $stable(rsp_is_edge)
         && $stable(rsp_first_witness) && $stable(rsp_match_total)
         && $stable(rsp_last)))
      else $error("rsp payload changed while stalled");

   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_edge == (rsp_match_total != '0)))
      else $error("edge flag disagrees with match total");

   a_first_none: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_edge) |-> (rsp_first_witness == '0))
      else $error("first witness set without an edge");

endmodule

bind mod3_matrix_coset_adjacency_top m3ca_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_rep_j         (rsp_chan.rep_j),
   .rsp_is_edge       (rsp_chan.is_edge),
   .rsp_first_witness (rsp_chan.first_witness),
   .rsp_match_total   (rsp_chan.match_total),
   .rsp_last          (rsp_chan.last)
);

[dv/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import m3ca_pkg::*;

   localparam int REP_DEPTH   = 64;
   localparam int WIT_DEPTH   = 256;
   localparam int DIM         = 4;
   localparam int IDLE_PAUSE  = 16;
   localparam int TAIL_CYCLES = 40;
   localparam int QUIET_LIMIT = 20000;
   localparam int NUM_PHASES  = 6;
   localparam int PHASE_OPS   = 3;

   localparam logic [ACTION_W-1:0]  ACT_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 8'd5;

   typedef enum logic [1:0] {STEP_REQ, STEP_FIXED, STEP_CSR} step_kind_type;

   typedef struct packed {
      logic [ACTION_W-1:0]                action;
      logic [SLOT_W-1:0]                  slot;
      logic [ROWIDX_W-1:0]                row;
      logic [LABEL_W-1:0]                 label;
      logic [ROW_STRIDE-1:0][ENTRY_W-1:0] ents;
   } req_item_type;

   typedef struct packed {
      logic [REP_J_W-1:0]   rep_j;
      logic                 is_edge;
      logic [WIT_OUT_W-1:0] first_witness;
      logic [TOTAL_W-1:0]   match_total;
      logic                 last;
   } adj_beat_type;

   typedef struct packed {
      step_kind_type         kind;
      req_item_type          item;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      adj_beat_type          res;
   } dir_step_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   m3ca_req_if req_bus ();
   m3ca_rsp_if rsp_bus ();
   m3ca_csr_if csr_bus ();

   mod3_matrix_coset_adjacency_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   mat_type                rep_tab [REP_DEPTH];
   mat_type                wit_tab [WIT_DEPTH];
   logic [LABEL_W-1:0]     wit_lab [WIT_DEPTH];
   logic [DIM-1:0]         rep_rows [REP_DEPTH];
   logic [DIM-1:0]         wit_rows [WIT_DEPTH];
   logic [REP_COUNT_W-1:0] cfg_reps = 7'd1;
   logic [WIT_COUNT_W-1:0] cfg_wits = 9'd0;

   adj_beat_type expected_adjacency [$];
   dir_step_type plan [$];
   int           err_count  = 0;
   int           burst_left = 0;
   int           stall_left = 0;
   int           run_left   = 0;
   int           quiet      = 0;

   function automatic int eff_reps();
      return (cfg_reps > REP_DEPTH) ? REP_DEPTH : int'(cfg_reps);
   endfunction

   function automatic int eff_wits();
      return (cfg_wits > WIT_DEPTH) ? WIT_DEPTH : int'(cfg_wits);
   endfunction

   function automatic res_type to_res(logic signed [ENTRY_W-1:0] v);
      int s;
      s = int'(v) % 3;
      if (s < 0) s += 3;
      return res_type'(s);
   endfunction

   // a * w == target, elementwise mod 3
   function automatic bit links(mat_type a, mat_type w, mat_type target);
      int s;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            s = 0;
            for (int k = 0; k < DIM; k++) s += int'(a[r][k]) * int'(w[k][c]);
            if (s % 3 != int'(target[r][c])) return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // transpose(b) * a, the inverse of b times a when b is a signed permutation
   function automatic mat_type tmul(mat_type b, mat_type a);
      mat_type m;
      int s;
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            s = 0;
            for (int k = 0; k < DIM; k++) s += int'(b[k][r]) * int'(a[k][c]);
            m[r][c] = res_type'(s % 3);
         end
      end
      return m;
   endfunction

   function automatic mat_type signed_perm(bit unit_only);
      int      p [DIM];
      int      x, t;
      mat_type m;
      m = '0;
      for (int i = 0; i < DIM; i++) p[i] = i;
      if (!unit_only) begin
         for (int i = DIM - 1; i > 0; i--) begin
            x = $urandom_range(0, i);
            t = p[i];
            p[i] = p[x];
            p[x] = t;
         end
      end
      for (int r = 0; r < DIM; r++) m[r][p[r]] = unit_only ? 2'd1 : res_type'($urandom_range(1, 2));
      return m;
   endfunction

   function automatic mat_type mat_rand();
      mat_type m;
      for (int r = 0; r < DIM; r++)
         for (int c = 0; c < DIM; c++) m[r][c] = res_type'($urandom_range(0, 2));
      return m;
   endfunction

   function automatic int full_rep();
      int hi, a;
      hi = (eff_reps() > 0) ? eff_reps() - 1 : 0;
      for (int t = 0; t < 8; t++) begin
         a = $urandom_range(0, hi);
         if (rep_rows[a] == '1) return a;
      end
      return -1;
   endfunction

   function automatic mat_type pick_rep_mat();
      int kind, a;
      kind = $urandom_range(0, 9);
      if (kind == 7) begin
         a = full_rep();
         if (a >= 0) return rep_tab[a];
      end
      if (kind == 6) return signed_perm(1'b1);
      if (kind >= 8) return mat_rand();
      return signed_perm(1'b0);
   endfunction

   function automatic mat_type pick_wit_mat();
      int kind, a, b;
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
         a = full_rep();
         b = full_rep();
         if (a >= 0 && b >= 0) return tmul(rep_tab[b], rep_tab[a]);
      end
      if (kind == 5) return signed_perm(1'b1);
      if (kind == 9) return mat_rand();
      return signed_perm(1'b0);
   endfunction

   // a 16-bit value with the given residue, spread over the whole range
   function automatic logic [ENTRY_W-1:0] spread(res_type r);
      int hi_v, lo_v;
      if ($urandom_range(0, 15) == 0) begin
         case (r)
            2'd0: begin
               hi_v = 32766;
               lo_v = -32766;
            end
            2'd1: begin
               hi_v = 32767;
               lo_v = -32768;
            end
            default: begin
               hi_v = 32765;
               lo_v = -32767;
            end
         endcase
         return 16'($urandom_range(0, 1) ? hi_v : lo_v);
      end
      return 16'(-32766 + 3 * int'($urandom_range(0, 21843)) + int'(r));
   endfunction

   task automatic predict_adjacency(input req_item_type it);
      int           nreps, nwit, total, first;
      bit           hit;
      adj_beat_type res;
      nreps = eff_reps();
      nwit  = eff_wits();
      case (it.action)
         ACT_LOAD_REP: begin
            if (it.slot < REP_DEPTH) begin
               for (int c = 0; c < DIM; c++) rep_tab[it.slot][it.row][c] = to_res(it.ents[c]);
               rep_rows[it.slot][it.row] = 1'b1;
            end
         end
         ACT_LOAD_WIT: begin
            for (int c = 0; c < DIM; c++) wit_tab[it.slot][it.row][c] = to_res(it.ents[c]);
            wit_rows[it.slot][it.row] = 1'b1;
            wit_lab[it.slot] = it.label;
         end
         ACT_QUERY: begin
            if (it.slot < nreps) begin
               for (int j = it.slot; j < nreps; j++) begin
                  hit   = 1'b0;
                  first = 0;
                  total = 0;
                  for (int k = 0; k < nwit; k++) begin
                     if (wit_lab[k] == it.label && links(rep_tab[j], wit_tab[k], rep_tab[it.slot])) begin
                        if (!hit) first = k;
                        hit = 1'b1;
                        if (total < 511) total++;
                     end
                  end
                  res.rep_j         = REP_J_W'(j);
                  res.is_edge       = hit;
                  res.first_witness = WIT_OUT_W'(first);
                  res.match_total   = TOTAL_W'(total);
                  res.last          = (j == nreps - 1);
                  expected_adjacency = {expected_adjacency, res};
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_req(input req_item_type it, input bit fixed, input adj_beat_type fixed_res);
      @(negedge clock);
      if (burst_left == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      end
      burst_left--;
      req_bus.valid      <= 1'b1;
      req_bus.action     <= it.action;
      req_bus.slot       <= it.slot;
      req_bus.row_index  <= it.row;
      req_bus.edge_label <= it.label;
      req_bus.entry0     <= it.ents[0];
      req_bus.entry1     <= it.ents[1];
      req_bus.entry2     <= it.ents[2];
      req_bus.entry3     <= it.ents[3];
      do @(posedge clock); while (!req_bus.ready);
      if (fixed) expected_adjacency = {expected_adjacency, fixed_res};
      else predict_adjacency(it);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_adjacency.size() != 0) @(posedge clock);
      repeat (IDLE_PAUSE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      wait_idle();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_REP_COUNT: cfg_reps = data[REP_COUNT_W-1:0];
         CSR_WIT_COUNT: cfg_wits = data[WIT_COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_matrix(input logic [ACTION_W-1:0] act, input int slot, input int label,
                              input mat_type m);
      req_item_type it;
      for (int r = 0; r < DIM; r++) begin
         it.action = act;
         it.slot   = SLOT_W'(slot);
         it.row    = ROWIDX_W'(r);
         it.label  = LABEL_W'(label);
         for (int c = 0; c < DIM; c++) it.ents[c] = spread(m[r][c]);
         send_req(it, 1'b0, '0);
      end
   endtask

   // every matrix that a query on this slot reads must be fully written
   task automatic fill_tables(input int slot);
      int nreps, nwit;
      nreps = eff_reps();
      nwit  = eff_wits();
      if (slot < nreps) begin
         for (int j = slot; j < nreps; j++)
            if (rep_rows[j] != '1) load_matrix(ACT_LOAD_REP, j, $urandom_range(0, 63), pick_rep_mat());
         for (int k = 0; k < nwit; k++)
            if (wit_rows[k] != '1) load_matrix(ACT_LOAD_WIT, k, $urandom_range(0, 3), pick_wit_mat());
      end
   endtask

   task automatic random_op();
      int           pick, nreps, nwit, slot, lbl;
      logic [95:0]  raw;
      req_item_type it;
      nreps = eff_reps();
      nwit  = eff_wits();
      pick  = $urandom_range(0, 99);
      lbl   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
      raw   = {$urandom, $urandom, $urandom};
      it    = raw[$bits(req_item_type)-1:0];
      if (pick < 40) begin
         if (nreps == 0 || $urandom_range(0, 9) == 0) slot = $urandom_range(0, 255);
         else if (nreps > 16 && $urandom_range(0, 9) != 0) slot = $urandom_range(nreps - 4, nreps - 1);
         else slot = $urandom_range(0, nreps - 1);
         fill_tables(slot);
         it.action = ACT_QUERY;
         it.slot   = SLOT_W'(slot);
         it.label  = LABEL_W'(lbl);
         send_req(it, 1'b0, '0);
      end else if (pick < 62) begin
         slot = $urandom_range(0, (nreps + 1 > REP_DEPTH - 1) ? REP_DEPTH - 1 : nreps + 1);
         load_matrix(ACT_LOAD_REP, slot, lbl, pick_rep_mat());
      end else if (pick < 85) begin
         slot = $urandom_range(0, (nwit + 1 > WIT_DEPTH - 1) ? WIT_DEPTH - 1 : nwit + 1);
         load_matrix(ACT_LOAD_WIT, slot, lbl, pick_wit_mat());
      end else begin
         case ($urandom_range(0, 2))
            0: it.action = ACT_SPARE;
            1: begin
               it.action = ACT_LOAD_REP;
               it.slot   = SLOT_W'($urandom_range(REP_DEPTH, 255));
            end
            default: it.action = ACT_LOAD_WIT;
         endcase
         send_req(it, 1'b0, '0);
      end
   endtask

   function automatic dir_step_type ld(logic [ACTION_W-1:0] act, int slot, int row, int label,
                                       int e0, int e1, int e2, int e3);
      dir_step_type s;
      s = '0;
      s.kind         = STEP_REQ;
      s.item.action  = act;
      s.item.slot    = SLOT_W'(slot);
      s.item.row     = ROWIDX_W'(row);
      s.item.label   = LABEL_W'(label);
      s.item.ents[0] = 16'(e0);
      s.item.ents[1] = 16'(e1);
      s.item.ents[2] = 16'(e2);
      s.item.ents[3] = 16'(e3);
      return s;
   endfunction

   function automatic dir_step_type qry(int slot, int label);
      return ld(ACT_QUERY, slot, 0, label, 0, 0, 0, 0);
   endfunction

   function automatic dir_step_type qfix(int slot, int label, int j, bit hit, int first, int total,
                                         bit last);
      dir_step_type s;
      s      = ld(ACT_QUERY, slot, 0, label, 0, 0, 0, 0);
      s.kind = STEP_FIXED;
      s.res  = '{REP_J_W'(j), hit, WIT_OUT_W'(first), TOTAL_W'(total), last};
      return s;
   endfunction

   function automatic dir_step_type cw(logic [CSR_IDX_W-1:0] idx, int data);
      dir_step_type s;
      s      = '0;
      s.kind = STEP_CSR;
      s.idx  = idx;
      s.data = CSR_DATA_W'(data);
      return s;
   endfunction

   // result checker
   always @(posedge clock) begin : rsp_check
      adj_beat_type seen, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.rep_j, rsp_bus.is_edge, rsp_bus.first_witness, rsp_bus.match_total,
                  rsp_bus.last};
         if (expected_adjacency.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected result beat: j=%0d edge=%0d first=%0d total=%0d last=%0d",
                        seen.rep_j, seen.is_edge, seen.first_witness, seen.match_total, seen.last);
         end else begin
            want = expected_adjacency.pop_front();
            if (seen.rep_j !== want.rep_j || seen.is_edge !== want.is_edge ||
                seen.first_witness !== want.first_witness ||
                seen.match_total !== want.match_total || seen.last !== want.last) begin
               err_count++;
               if (err_count <= 10)
                  $display("result mismatch: exp j=%0d edge=%0d first=%0d total=%0d last=%0d,",
                           want.rep_j, want.is_edge, want.first_witness, want.match_total,
                           want.last,
                           " got j=%0d edge=%0d first=%0d total=%0d last=%0d",
                           seen.rep_j, seen.is_edge, seen.first_witness,
                           seen.match_total, seen.last);
            end
         end
      end
   end

   // result-side backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left--;
      end else if (run_left > 0) begin
         rsp_bus.ready <= 1'b1;
         run_left--;
      end else begin
         rsp_bus.ready <= 1'b1;
         case ($urandom_range(0, 3))
            0: run_left = $urandom_range(20, 80);
            1: stall_left = $urandom_range(10, 30);
            default: begin
               stall_left = $urandom_range(0, 3);
               run_left   = $urandom_range(0, 4);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   initial begin
      int reps_set [6];
      int wits_set [6];
      int reps, wits;
      reps_set = '{3, 0, 8, 127, 64, 1};
      wits_set = '{4, 2, 0, 9, 6, 1};
      req_bus.valid      = 1'b0;
      req_bus.action     = '0;
      req_bus.slot       = '0;
      req_bus.row_index  = '0;
      req_bus.edge_label = '0;
      req_bus.entry0     = '0;
      req_bus.entry1     = '0;
      req_bus.entry2     = '0;
      req_bus.entry3     = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      for (int i = 0; i < REP_DEPTH; i++) rep_rows[i] = '0;
      for (int i = 0; i < WIT_DEPTH; i++) wit_rows[i] = '0;

      plan = '{
         // rep 0 = identity, entries at the range extremes
         ld(ACT_LOAD_REP, 0, 0, 0, 32767, -3, 3, 0),
         ld(ACT_LOAD_REP, 0, 1, 0, 0, -32768, 32766, -32766),
         ld(ACT_LOAD_REP, 0, 2, 0, 0, 0, 4, -30000),
         ld(ACT_LOAD_REP, 0, 3, 0, -6, 9, -12, -2),
         // reset counts: one rep, empty witness table
         qfix(0, 0, 0, 1'b0, 0, 0, 1'b1),
         ld(ACT_SPARE, 0, 0, 0, 5, 5, 5, 5),
         qry(1, 0),
         ld(ACT_LOAD_REP, 200, 0, 0, 1, 1, 1, 1),
         // witness 0 = identity, witness 1 = minus identity, both label 5
         ld(ACT_LOAD_WIT, 0, 0, 5, 1, 0, 0, 0),
         ld(ACT_LOAD_WIT, 0, 1, 5, 0, -32765, 0, 0),
         ld(ACT_LOAD_WIT, 0, 2, 5, 0, 0, 4, 0),
         ld(ACT_LOAD_WIT, 0, 3, 5, 0, 0, 0, 7),
         ld(ACT_LOAD_WIT, 1, 0, 5, -1, 0, 0, 0),
         ld(ACT_LOAD_WIT, 1, 1, 5, 0, 2, 0, 0),
         ld(ACT_LOAD_WIT, 1, 2, 5, 0, 0, 32765, 0),
         ld(ACT_LOAD_WIT, 1, 3, 5, 0, 0, 0, -32767),
         cw(CSR_WIT_COUNT, 2),
         qfix(0, 5, 0, 1'b1, 0, 1, 1'b1),
         qfix(0, 63, 0, 1'b0, 0, 0, 1'b1),
         // rep 1 = minus identity
         ld(ACT_LOAD_REP, 1, 0, 0, 2, 0, 0, 0),
         ld(ACT_LOAD_REP, 1, 1, 0, 0, -1, 0, 0),
         ld(ACT_LOAD_REP, 1, 2, 0, 0, 0, -4, 0),
         ld(ACT_LOAD_REP, 1, 3, 0, 0, 0, 0, 5),
         cw(CSR_REP_COUNT, 2),
         qry(0, 5),
         qfix(1, 5, 1, 1'b1, 0, 1, 1'b1),
         // zero reps gives nothing; unused register index is a no-op
         cw(CSR_REP_COUNT, 0),
         qry(0, 5),
         cw(CSR_SPARE, 16'hffff),
         qry(0, 0)
      };

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         case (plan[i].kind)
            STEP_CSR:   csr_write(plan[i].idx, plan[i].data);
            STEP_FIXED: send_req(plan[i].item, 1'b1, plan[i].res);
            default:    send_req(plan[i].item, 1'b0, '0);
         endcase
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         reps = (p < 6) ? reps_set[p] : $urandom_range(1, 10);
         wits = (p < 6) ? wits_set[p] : $urandom_range(0, 16);
         csr_write(CSR_WIT_COUNT, CSR_DATA_W'(($urandom_range(0, 127) << 9) | wits));
         csr_write(CSR_REP_COUNT, CSR_DATA_W'(($urandom_range(0, 511) << 7) | reps));
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
         repeat (PHASE_OPS) random_op();
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0 && expected_adjacency.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
